// ----- hw/rtl/fpr_pkg.sv -----
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int ADDR_BITS    = 32;
  localparam int PAGE_SHIFT   = 12;
  localparam int PAGE_W       = ADDR_BITS - PAGE_SHIFT;
  localparam int NUM_FRAMES_W = 7;
  localparam int CNT_W        = 32;
  localparam int FRAMES_DFLT  = 64;
  localparam int FRAMES_CFG_MAX = 64;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PAGE_W-1:0] page_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ----- hw/rtl/fifo_page_replacement_top.sv -----
`timescale 1ns / 1ps

// channel   dir   signals                          beat taken when
// cmd       in    start, address, is_write         start && !busy
// result    out   done, hit, evicted, ...          done (one cycle)
// config    in    cfg_we, cfg_wdata                cfg_we
//
// one access per cycle; its result passes the input register and then the result register
// tag lookup is a parallel compare over all FRAMES slots, state updated in the same cycle
// busy never rises; the result channel cannot stall
// synchronous reset clears valid bits, queue pointers and counters
// num_frames resets to the smaller of FRAMES and 64

module fifo_page_replacement_top #(
  parameter int FRAMES = fpr_pkg::FRAMES_DFLT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fpr_pkg::ADDR_BITS-1:0]    address,
  input  logic                             is_write,
  input  logic                             cfg_we,
  input  logic [fpr_pkg::NUM_FRAMES_W-1:0] cfg_wdata,
  output logic                             done,
  output logic                             hit,
  output logic                             evicted,
  output logic                             dirty_writeback,
  output logic [fpr_pkg::PAGE_W-1:0]       victim_page,
  output logic [fpr_pkg::CNT_W-1:0]        disk_reads,
  output logic [fpr_pkg::CNT_W-1:0]        disk_writes,
  output logic [fpr_pkg::CNT_W-1:0]        events
);

  import fpr_pkg::*;

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W  = $clog2(FRAMES + 1);
  localparam int CMP_W  = (OCC_W > NUM_FRAMES_W) ? OCC_W : NUM_FRAMES_W;
  localparam int SUM_W  = ((SLOT_W > OCC_W) ? SLOT_W : OCC_W) + 1;
  localparam int NF_RST = (FRAMES < FRAMES_CFG_MAX) ? FRAMES : FRAMES_CFG_MAX;

  logic [NUM_FRAMES_W-1:0] num_frames;
  logic                    s1_valid;
  page_t                   s1_page;
  logic                    s1_wr;

  page_t             page_tags [FRAMES];
  logic [FRAMES-1:0] frame_dirty;
  logic [FRAMES-1:0] frame_valid;
  logic [SLOT_W-1:0] oldest_slot;
  logic [OCC_W-1:0]  occupancy;
  cnt_t              read_counter;
  cnt_t              write_counter;
  cnt_t              event_counter;

  logic [FRAMES-1:0] match;
  logic              hit_c;
  logic              evict_c;
  logic [CMP_W-1:0]  nf_ext;
  logic [CMP_W-1:0]  frames_ext;
  logic [CMP_W-1:0]  active_ext;
  logic [CMP_W-1:0]  occ_ext;
  page_t             victim_tag;
  logic              victim_dirty;
  logic [SLOT_W-1:0] oldest_inc;
  logic [SLOT_W-1:0] oldest_after;
  logic [OCC_W-1:0]  occ_after;
  logic [SUM_W-1:0]  ins_sum;
  logic [SLOT_W-1:0] ins_slot;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_page <= address[ADDR_BITS-1:PAGE_SHIFT];
      s1_wr   <= is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_W'(NF_RST);
    end else if (cfg_we) begin
      num_frames <= cfg_wdata;
    end
  end

  // lookup and replacement decision
  always_comb begin
    nf_ext     = CMP_W'(num_frames);
    frames_ext = CMP_W'(FRAMES);
    occ_ext    = CMP_W'(occupancy);
    if (nf_ext == '0) begin
      active_ext = CMP_W'(1);
    end else if (nf_ext > frames_ext) begin
      active_ext = frames_ext;
    end else begin
      active_ext = nf_ext;
    end
    hit_c        = |match;
    evict_c      = !hit_c && ((occ_ext >= active_ext) || (occupancy >= OCC_W'(FRAMES)));
    victim_tag   = page_tags[oldest_slot];
    victim_dirty = frame_dirty[oldest_slot];
    oldest_inc   = (oldest_slot == SLOT_W'(FRAMES - 1)) ? '0 : oldest_slot + SLOT_W'(1);
    oldest_after = evict_c ? oldest_inc : oldest_slot;
    occ_after    = evict_c ? occupancy - OCC_W'(1) : occupancy;
    ins_sum      = SUM_W'(oldest_after) + SUM_W'(occ_after);
    if (ins_sum >= SUM_W'(FRAMES)) begin
      ins_slot = SLOT_W'(ins_sum - SUM_W'(FRAMES));
    end else begin
      ins_slot = SLOT_W'(ins_sum);
    end
  end

  // one compare and one update per slot
  for (genvar i = 0; i < FRAMES; i++) begin : g_slot
    logic is_ins;
    logic is_old;

    assign match[i] = frame_valid[i] && (page_tags[i] == s1_page);
    assign is_ins   = (ins_slot == SLOT_W'(i));
    assign is_old   = (oldest_slot == SLOT_W'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        frame_valid[i] <= 1'b0;
      end else if (s1_valid && !hit_c) begin
        if (is_ins) begin
          frame_valid[i] <= 1'b1;
        end else if (evict_c && is_old) begin
          frame_valid[i] <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (s1_valid) begin
        if (hit_c) begin
          if (match[i] && s1_wr) begin
            frame_dirty[i] <= 1'b1;
          end
        end else if (is_ins) begin
          page_tags[i]   <= s1_page;
          frame_dirty[i] <= s1_wr;
        end
      end
    end
  end

  // queue pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot   <= '0;
      occupancy     <= '0;
      read_counter  <= '0;
      write_counter <= '0;
      event_counter <= '0;
    end else if (s1_valid) begin
      event_counter <= sat_inc(event_counter);
      if (!hit_c) begin
        read_counter <= sat_inc(read_counter);
        oldest_slot  <= oldest_after;
        occupancy    <= occ_after + OCC_W'(1);
        if (evict_c && victim_dirty) begin
          write_counter <= sat_inc(write_counter);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      hit             <= hit_c;
      evicted         <= evict_c;
      dirty_writeback <= evict_c && victim_dirty;
      victim_page     <= evict_c ? victim_tag : '0;
    end
  end

  assign disk_reads  = read_counter;
  assign disk_writes = write_counter;
  assign events      = event_counter;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(FRAMES))
    else $error("occupancy above frame count");

  a_hit_one: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(match))
    else $error("page resident in more than one slot");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("result beat missing");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evicted && !dirty_writeback))
    else $error("eviction on a hit");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted) |-> ((victim_page == '0) && !dirty_writeback))
    else $error("victim reported without eviction");

endmodule
